// ===== rtl/cidfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cidfr_pkg
// Shared types and constants for the connection ID flow router.
// ----------------------------------------------------------------------------
package cidfr_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int MAX_SLOTS_DEF     = 16;
    localparam int ID_BYTES_DEF      = 8;

    localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
    localparam logic [63:0] FNV_PRIME = 64'h00000100000001b3;

    localparam logic FUNC_ROUTE = 1'b0;
    localparam logic FUNC_CLOSE = 1'b1;

    localparam int IN_W  = 137;
    localparam int OUT_W = 46;

    typedef struct packed {
        logic        func;
        logic [63:0] conn_id;
        logic [3:0]  conn_id_bytes;
        logic [63:0] source_key;
        logic [3:0]  source_key_bytes;
    } item_t;

    typedef struct packed {
        logic        dropped;
        logic [3:0]  slot;
        logic        was_known;
        logic        table_full;
        logic [31:0] slot_packet_count;
        logic [6:0]  entries_left;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SEARCH, ST_RDWAIT, ST_HASH, ST_MUL, ST_MOD,
        ST_COMMIT, ST_CNT_RD, ST_CNT_WR, ST_OUT
    } bk_state_t;

    function automatic logic [63:0] top_mask(input logic [3:0] n);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++)
            if (4'(i) < n)
                m[63 - 8*i -: 8] = 8'hff;
        return m;
    endfunction

    // h * FNV_PRIME mod 2^64, prime = 2^40 + 0x1b3
    function automatic logic [63:0] fnv_mul(input logic [63:0] h);
        return (h << 40) + (h << 8) + (h << 7) + (h << 5) + (h << 4) + (h << 1) + h;
    endfunction

endpackage

// ===== rtl/cidfr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cidfr_front
// Accepts beats, masks and clamps the ID, and queues classified items.
// ----------------------------------------------------------------------------
module cidfr_front #(
    parameter int ID_BYTES = cidfr_pkg::ID_BYTES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  cidfr_pkg::item_t in_item,
    output logic             q_valid,
    input  logic             q_ready,
    output cidfr_pkg::item_t q_item
);
    import cidfr_pkg::*;

    localparam int QD = 2;

    item_t      q_reg [QD];
    logic       wp_reg, rp_reg, wp_next, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    item_t      cls;
    logic [3:0] len;

    always_comb
    begin
        len = (in_item.conn_id_bytes > 4'(ID_BYTES)) ? 4'(ID_BYTES) : in_item.conn_id_bytes;
        cls = in_item;
        cls.conn_id_bytes = len;
        cls.conn_id = in_item.conn_id & top_mask(len);
        cls.source_key_bytes = (in_item.source_key_bytes > 4'd8) ? 4'd8
                                                                  : in_item.source_key_bytes;
    end

    assign in_ready = (cnt_reg != 2'(QD));
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = q_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (in_valid && in_ready)
        begin
            wp_next = ~wp_reg;
            cnt_next = cnt_next + 2'd1;
        end
        if (q_valid && q_ready)
        begin
            rp_next = ~rp_reg;
            cnt_next = cnt_next - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            q_reg[wp_reg] <= cls;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= '0;
        end
        else
        begin
            wp_reg <= wp_next; rp_reg <= rp_next; cnt_reg <= cnt_next;
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'(QD))
        else $error("queue count overflow");
    a_full_block: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'(QD) |-> !in_ready) else $error("accept while full");
    a_len_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid |-> q_item.conn_id_bytes <= 4'(ID_BYTES)) else $error("length not clamped");
endmodule

// ===== rtl/cidfr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cidfr_back
// Table search, FNV-1a hash, slot modulo, insert/remove and slot counters.
// ----------------------------------------------------------------------------
module cidfr_back #(
    parameter int TABLE_ENTRIES = cidfr_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_SLOTS     = cidfr_pkg::MAX_SLOTS_DEF,
    parameter int ID_BYTES      = cidfr_pkg::ID_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [4:0]         slot_count,
    input  logic               q_valid,
    output logic               q_ready,
    input  cidfr_pkg::item_t   q_item,
    output logic               out_valid,
    input  logic               out_ready,
    output cidfr_pkg::result_t out_res
);
    import cidfr_pkg::*;

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int TW = $clog2(TABLE_ENTRIES + 1);
    localparam int LW = $clog2(ID_BYTES + 1);

    // table memory: id, length, slot
    logic [63:0]   mem_id  [TABLE_ENTRIES];
    logic [LW-1:0] mem_len [TABLE_ENTRIES];
    logic [SW-1:0] mem_slt [TABLE_ENTRIES];
    logic [31:0]   cnt_mem [MAX_SLOTS];
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;

    bk_state_t state_reg, state_next;
    item_t     it_reg, it_next;
    logic [AW:0]   idx_reg, idx_next;
    logic [AW-1:0] rd_idx_reg;
    logic          rd_ok_reg;
    logic [63:0]   rd_id_reg;
    logic [LW-1:0] rd_len_reg;
    logic [SW-1:0] rd_slt_reg;
    logic          found_reg, found_next;
    logic [AW-1:0] hit_reg, hit_next;
    logic          free_ok_reg, free_ok_next;
    logic [AW-1:0] free_reg, free_next;
    logic [63:0]   h_reg, h_next;
    logic [3:0]    bi_reg, bi_next;
    logic [68:0]   rem_reg, rem_next;
    logic [6:0]    mb_reg, mb_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic [TW-1:0] total_reg, total_next;
    logic [31:0]   cnt_rd_reg;
    logic [31:0]   cnt_cur;
    result_t       res_reg, res_next;
    logic [4:0]    eff;
    logic [63:0]   hx;
    logic [68:0]   trial;
    logic          rd_match;
    logic          ins;

    assign eff = (slot_count == 5'd0) ? 5'd1
               : ((32'(slot_count) > MAX_SLOTS) ? 5'(MAX_SLOTS) : slot_count);
    assign hx = h_reg ^ {56'd0, it_reg.source_key[63 - 8*bi_reg[2:0] -: 8]};
    assign trial = 69'(eff) << mb_reg;
    assign rd_match = rd_ok_reg && valid_reg[rd_idx_reg]
                      && rd_len_reg == LW'(it_reg.conn_id_bytes) && rd_id_reg == it_reg.conn_id;
    assign ins = !found_reg && free_ok_reg;

    // unwritten packet counters read as zero
    cidfr_cnt #(.MAX_SLOTS(MAX_SLOTS)) u_cnt (
        .clk(clk), .rst_n(rst_n), .wr(state_reg == ST_CNT_WR), .idx(slot_reg),
        .raw(cnt_rd_reg), .val(cnt_cur)
    );

    always_ff @(posedge clk)
    begin
        rd_id_reg  <= mem_id[idx_reg[AW-1:0]];
        rd_len_reg <= mem_len[idx_reg[AW-1:0]];
        rd_slt_reg <= mem_slt[idx_reg[AW-1:0]];
        rd_idx_reg <= idx_reg[AW-1:0];
        cnt_rd_reg <= cnt_mem[slot_reg];
        if (state_reg == ST_COMMIT && it_reg.func == FUNC_ROUTE && ins)
        begin
            mem_id[free_reg]  <= it_reg.conn_id;
            mem_len[free_reg] <= LW'(it_reg.conn_id_bytes);
            mem_slt[free_reg] <= slot_reg;
        end
        if (state_reg == ST_CNT_WR)
            cnt_mem[slot_reg] <= (cnt_cur == 32'hffffffff) ? cnt_cur : cnt_cur + 32'd1;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (q_valid)
                           state_next = (q_item.func == FUNC_ROUTE
                                         && q_item.conn_id_bytes == 4'd0) ? ST_OUT : ST_SEARCH;
            ST_SEARCH: if (idx_reg == (AW+1)'(TABLE_ENTRIES)) state_next = ST_RDWAIT;
            ST_RDWAIT: state_next = (it_reg.func == FUNC_CLOSE || found_next) ? ST_COMMIT
                                                                               : ST_HASH;
            ST_HASH:   state_next = (bi_reg == it_reg.source_key_bytes) ? ST_MOD : ST_MUL;
            ST_MUL:    state_next = ST_HASH;
            ST_MOD:    if (mb_reg == 7'd0) state_next = ST_COMMIT;
            ST_COMMIT: state_next = (it_reg.func == FUNC_CLOSE) ? ST_OUT : ST_CNT_RD;
            ST_CNT_RD: state_next = ST_CNT_WR;
            ST_CNT_WR: state_next = ST_OUT;
            ST_OUT:    if (out_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        it_next = it_reg; idx_next = idx_reg; found_next = found_reg; hit_next = hit_reg;
        free_ok_next = free_ok_reg; free_next = free_reg; h_next = h_reg; bi_next = bi_reg;
        rem_next = rem_reg; mb_next = mb_reg; slot_next = slot_reg; total_next = total_reg;
        valid_next = valid_reg; res_next = res_reg;
        case (state_reg)
            ST_IDLE:
            begin
                it_next = q_item; idx_next = '0; found_next = 1'b0; free_ok_next = 1'b0;
                res_next = '0; h_next = FNV_BASIS; bi_next = '0;
                if (q_item.func == FUNC_ROUTE && q_item.conn_id_bytes == 4'd0)
                    res_next.dropped = 1'b1;
            end
            ST_SEARCH, ST_RDWAIT:
            begin
                if (state_reg == ST_SEARCH)
                    idx_next = idx_reg + 1'b1;
                if (rd_ok_reg && !found_reg && rd_match)
                begin
                    found_next = 1'b1; hit_next = rd_idx_reg;
                    slot_next = rd_slt_reg;
                end
                if (rd_ok_reg && !free_ok_reg && !valid_reg[rd_idx_reg])
                begin
                    free_ok_next = 1'b1; free_next = rd_idx_reg;
                end
            end
            ST_HASH: if (bi_reg != it_reg.source_key_bytes) h_next = hx;
            ST_MUL:
            begin
                h_next = fnv_mul(h_reg);
                bi_next = bi_reg + 4'd1;
                rem_next = {5'd0, h_next};
                mb_next = 7'd64;
            end
            ST_MOD:
            begin
                if (trial <= rem_reg) rem_next = rem_reg - trial;
                if (mb_reg != 7'd0) mb_next = mb_reg - 7'd1;
                else slot_next = SW'(rem_next);
            end
            ST_COMMIT:
            begin
                if (it_reg.func == FUNC_CLOSE)
                begin
                    if (found_reg && it_reg.conn_id_bytes != 4'd0)
                    begin
                        valid_next[hit_reg] = 1'b0;
                        if (total_reg != '0) total_next = total_reg - 1'b1;
                        res_next.was_known = 1'b1;
                    end
                    res_next.entries_left = 7'(total_next);
                end
                else
                begin
                    res_next.was_known = found_reg;
                    if (ins)
                    begin
                        valid_next[free_reg] = 1'b1;
                        total_next = total_reg + 1'b1;
                    end
                    res_next.table_full = !found_reg && !free_ok_reg;
                end
            end
            ST_CNT_WR:
            begin
                res_next.slot = 4'(slot_reg);
                res_next.slot_packet_count = (cnt_cur == 32'hffffffff) ? cnt_cur
                                                                       : cnt_cur + 32'd1;
            end
            default: ;
        endcase
        // all source bytes hashed: start the modulo with the hash (the basis for zero bytes)
        if (state_reg == ST_HASH && bi_reg == it_reg.source_key_bytes)
        begin
            rem_next = {5'd0, h_reg};
            mb_next = 7'd64;
        end
    end

    assign q_ready   = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign out_res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE; valid_reg <= '0; total_reg <= '0; rd_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next; valid_reg <= valid_next; total_reg <= total_next;
            rd_ok_reg <= (state_reg == ST_SEARCH) && (idx_reg < (AW+1)'(TABLE_ENTRIES));
        end
    end

    always_ff @(posedge clk)
    begin
        it_reg <= it_next; idx_reg <= idx_next; found_reg <= found_next; hit_reg <= hit_next;
        free_ok_reg <= free_ok_next; free_reg <= free_next; h_reg <= h_next; bi_reg <= bi_next;
        rem_reg <= rem_next; mb_reg <= mb_next; slot_reg <= slot_next; res_reg <= res_next;
    end

    a_total: assert property (@(posedge clk) disable iff (!rst_n)
        32'(total_reg) == $countones(valid_reg)) else $error("entry count mismatch");
    a_drop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && res_reg.dropped |-> res_reg.slot_packet_count == 32'd0)
        else $error("dropped result not clean");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(res_reg)) else $error("result lost");
endmodule

// ===== rtl/cidfr_cnt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cidfr_cnt
// Per-slot valid flags that make unwritten packet counters read as zero.
// ----------------------------------------------------------------------------
module cidfr_cnt #(
    parameter int MAX_SLOTS = cidfr_pkg::MAX_SLOTS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    wr,
    input  logic [((MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1)-1:0] idx,
    input  logic [31:0]                             raw,
    output logic [31:0]                             val
);
    logic [MAX_SLOTS-1:0] seen_reg;

    assign val = seen_reg[idx] ? raw : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_reg <= '0;
        else if (wr)
            seen_reg[idx] <= 1'b1;
    end
endmodule

// ===== rtl/connection_id_flow_router.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// connection_id_flow_router
// Steers packets to engine slots by connection ID with a hashed flow table.
// ----------------------------------------------------------------------------
// One item at a time in the back end: after the accept cycle a route runs a
// full table scan, for a new ID hashes each source byte and runs a bit-serial
// modulo, then commits, updates the slot counter and presents the output,
// which is held while m_tready is low. A two-entry queue in front lets the
// next beat be taken while the back end works.
module connection_id_flow_router #(
    parameter int TABLE_ENTRIES = cidfr_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_SLOTS     = cidfr_pkg::MAX_SLOTS_DEF,
    parameter int ID_BYTES      = cidfr_pkg::ID_BYTES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [4:0]   cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // func, conn_id, conn_id_bytes, source_key, source_key_bytes (lsb first)
    input  logic [143:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // dropped, slot, was_known, table_full, slot_packet_count, entries_left
    output logic [47:0]  m_tdata
);
    import cidfr_pkg::*;

    logic [4:0] slot_count_reg;
    item_t      in_item, q_item;
    logic       q_valid, q_ready;
    result_t    res;

    assign in_item.func             = s_tdata[0];
    assign in_item.conn_id          = s_tdata[64:1];
    assign in_item.conn_id_bytes    = s_tdata[68:65];
    assign in_item.source_key       = s_tdata[132:69];
    assign in_item.source_key_bytes = s_tdata[136:133];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slot_count_reg <= 5'd2;
        else if (cfg_we)
            slot_count_reg <= cfg_wdata;
    end

    cidfr_front #(.ID_BYTES(ID_BYTES)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(s_tvalid), .in_ready(s_tready),
        .in_item(in_item), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    cidfr_back #(.TABLE_ENTRIES(TABLE_ENTRIES), .MAX_SLOTS(MAX_SLOTS),
                 .ID_BYTES(ID_BYTES)) u_back (
        .clk(clk), .rst_n(rst_n), .slot_count(slot_count_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
    );

    assign m_tdata = {2'b00, res.entries_left, res.slot_packet_count, res.table_full,
                      res.was_known, res.slot, res.dropped};
endmodule
